// File: sv/cpu_frequency_governor_macros.svh
// Assertion macros for the CPU frequency governor.
`ifndef CPU_FREQUENCY_GOVERNOR_MACROS_SVH
`define CPU_FREQUENCY_GOVERNOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define CPUFG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpufg assertion failed");
// Next-cycle implication, disabled during reset.
`define CPUFG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpufg assertion failed");
`else
`define CPUFG_ASSERT_IMPL(lbl, ante, cons)
`define CPUFG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/cpufg_pkg.sv
// Shared types and constants for the CPU frequency governor.
package cpufg_pkg;

    localparam int DEF_MAX_STATES     = 16;
    localparam int DEF_LOAD_FRAC_BITS = 16;

    localparam int AVG_W    = 17;
    localparam int CORE_W   = 7;
    localparam int COUNT_W  = 5;
    localparam int MODE_W   = 2;
    localparam int THR_W    = 23;
    localparam int PSTATE_W = 4;
    localparam int IDX_W    = 3;
    localparam int DATA_W   = 23;
    localparam int LOAD_W   = AVG_W + CORE_W;
    localparam int PROD_W   = LOAD_W + COUNT_W;
    localparam int MUL_B_W  = (CORE_W > COUNT_W) ? CORE_W : COUNT_W;
    localparam int MUL_W    = LOAD_W + MUL_B_W;

    localparam logic [IDX_W-1:0] CFG_GOVERNOR_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_STATE_COUNT    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CORE_COUNT     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_UP_THRESHOLD   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_DOWN_THRESHOLD = 3'd4;

    localparam logic [COUNT_W-1:0] RST_STATE_COUNT    = 5'd1;
    localparam logic [CORE_W-1:0]  RST_CORE_COUNT     = 7'd1;
    localparam logic [THR_W-1:0]   RST_UP_THRESHOLD   = 23'd52429;
    localparam logic [THR_W-1:0]   RST_DOWN_THRESHOLD = 23'd13107;

    typedef enum logic [MODE_W-1:0] {
        GOV_PERFORMANCE  = 2'd0,
        GOV_POWERSAVE    = 2'd1,
        GOV_ONDEMAND     = 2'd2,
        GOV_CONSERVATIVE = 2'd3
    } gov_mode_t;

    typedef enum logic [1:0] {
        S_IDLE     = 2'd0,
        S_MUL_LOAD = 2'd1,
        S_MUL_PROD = 2'd2,
        S_DECIDE   = 2'd3
    } fsm_t;

endpackage

// File: sv/cpu_frequency_governor.sv
// CPU frequency governor: picks the next performance state once per load sample.
// Steps per sample: load multiply, then compare and count multiply, then decide.
// The single shared multiplier means a new sample is taken only after the last one's decide step.
// A held result stalls the decide step and the input; the output register lets one more sample in.
// Reset (rst_n, async, active low): performance mode, one state, one core, state 0.
`include "cpu_frequency_governor_macros.svh"

module cpu_frequency_governor #(
    parameter int MAX_STATES     = cpufg_pkg::DEF_MAX_STATES,
    parameter int LOAD_FRAC_BITS = cpufg_pkg::DEF_LOAD_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cpufg_pkg::IDX_W-1:0]   cfg_index,
    input  logic [cpufg_pkg::DATA_W-1:0]  cfg_data,
    // load sample channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cpufg_pkg::AVG_W-1:0]   avg_load,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cpufg_pkg::PSTATE_W-1:0] next_state,
    output logic                          state_changed,
    output logic                          above_up
);

    localparam int COUNT_W = cpufg_pkg::COUNT_W;
    localparam int TOP_W   = COUNT_W + LOAD_FRAC_BITS;
    localparam int CMP_W   = (TOP_W > cpufg_pkg::PROD_W) ? TOP_W : cpufg_pkg::PROD_W;
    localparam logic [8:0] MAX_ST9 = 9'(MAX_STATES);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; unknown indexes drop.
    // ------------------------------------------------------------------
    cpufg_pkg::gov_mode_t                 mode_reg;
    logic [COUNT_W-1:0]                   state_count_reg;
    logic [cpufg_pkg::CORE_W-1:0]         core_count_reg;
    logic [cpufg_pkg::THR_W-1:0]          up_thr_reg;
    logic [cpufg_pkg::THR_W-1:0]          down_thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= cpufg_pkg::GOV_PERFORMANCE;
            state_count_reg <= cpufg_pkg::RST_STATE_COUNT;
            core_count_reg  <= cpufg_pkg::RST_CORE_COUNT;
            up_thr_reg      <= cpufg_pkg::RST_UP_THRESHOLD;
            down_thr_reg    <= cpufg_pkg::RST_DOWN_THRESHOLD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cpufg_pkg::CFG_GOVERNOR_MODE:
                    mode_reg <= cpufg_pkg::gov_mode_t'(cfg_data[cpufg_pkg::MODE_W-1:0]);
                cpufg_pkg::CFG_STATE_COUNT:
                    state_count_reg <= cfg_data[COUNT_W-1:0];
                cpufg_pkg::CFG_CORE_COUNT:
                    core_count_reg <= cfg_data[cpufg_pkg::CORE_W-1:0];
                cpufg_pkg::CFG_UP_THRESHOLD:
                    up_thr_reg <= cfg_data[cpufg_pkg::THR_W-1:0];
                cpufg_pkg::CFG_DOWN_THRESHOLD:
                    down_thr_reg <= cfg_data[cpufg_pkg::THR_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Effective state count: zero acts as one, anything above the limit saturates.
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] slowest;

    always_comb
    begin
        if (state_count_reg == '0)
            count = COUNT_W'(1);
        else if ({4'b0, state_count_reg} > MAX_ST9)
            count = COUNT_W'(MAX_STATES);
        else
            count = state_count_reg;
        slowest = count - COUNT_W'(1);
    end

    // ------------------------------------------------------------------
    // Sequencer and shared multiplier.
    // ------------------------------------------------------------------
    cpufg_pkg::fsm_t fsm_reg, fsm_next;

    logic [cpufg_pkg::AVG_W-1:0]   avg_reg;
    logic [cpufg_pkg::LOAD_W-1:0]  load_reg;
    logic [cpufg_pkg::PROD_W-1:0]  prod_reg;
    logic                          above_reg;
    logic                          below_reg;
    logic [cpufg_pkg::PSTATE_W-1:0] current_state_reg;

    logic [cpufg_pkg::LOAD_W-1:0]  mul_a;
    logic [cpufg_pkg::MUL_B_W-1:0] mul_b;
    logic [cpufg_pkg::MUL_W-1:0]   mul_p;

    logic in_take;
    logic out_free;
    logic load_en;
    logic prod_en;
    logic result_wr;

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid || !out_stall;
    assign mul_p    = cpufg_pkg::MUL_W'(mul_a) * cpufg_pkg::MUL_W'(mul_b);

    // Next state: wait in idle for a sample, advance one step per cycle, hold in decide until the output frees.
    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            cpufg_pkg::S_IDLE:
                if (in_take)
                    fsm_next = cpufg_pkg::S_MUL_LOAD;
            cpufg_pkg::S_MUL_LOAD:
                fsm_next = cpufg_pkg::S_MUL_PROD;
            cpufg_pkg::S_MUL_PROD:
                fsm_next = cpufg_pkg::S_DECIDE;
            cpufg_pkg::S_DECIDE:
                if (out_free)
                    fsm_next = cpufg_pkg::S_IDLE;
            default:
                fsm_next = cpufg_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: steer the multiplier and enable the holding registers.
    always_comb
    begin
        in_stall  = 1'b1;
        mul_a     = '0;
        mul_b     = '0;
        load_en   = 1'b0;
        prod_en   = 1'b0;
        result_wr = 1'b0;
        unique case (fsm_reg)
            cpufg_pkg::S_IDLE:
                in_stall = 1'b0;
            cpufg_pkg::S_MUL_LOAD:
            begin
                // scaled load = average load times core count
                mul_a   = cpufg_pkg::LOAD_W'(avg_reg);
                mul_b   = cpufg_pkg::MUL_B_W'(core_count_reg);
                load_en = 1'b1;
            end
            cpufg_pkg::S_MUL_PROD:
            begin
                // ondemand product = scaled load times state count
                mul_a   = load_reg;
                mul_b   = cpufg_pkg::MUL_B_W'(count);
                prod_en = 1'b1;
            end
            cpufg_pkg::S_DECIDE:
                result_wr = out_free;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fsm_reg <= cpufg_pkg::S_IDLE;
        else
            fsm_reg <= fsm_next;
    end

    // Datapath holding registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_take)
            avg_reg <= avg_load;
        if (load_en)
            load_reg <= mul_p[cpufg_pkg::LOAD_W-1:0];
        if (prod_en)
        begin
            prod_reg  <= mul_p[cpufg_pkg::PROD_W-1:0];
            // threshold compares run beside the second multiply
            above_reg <= load_reg > cpufg_pkg::LOAD_W'(up_thr_reg);
            below_reg <= load_reg < cpufg_pkg::LOAD_W'(down_thr_reg);
        end
    end

    // ------------------------------------------------------------------
    // Decide step: one subtract for ondemand, step logic for conservative; powersave slowest, else state 0.
    // ------------------------------------------------------------------
    logic [CMP_W-1:0]   top_ext;
    logic [CMP_W-1:0]   prod_ext;
    logic [CMP_W-1:0]   diff;
    logic [COUNT_W-1:0] od_val;
    logic [COUNT_W-1:0] cur_sat;
    logic [COUNT_W-1:0] next_val;

    always_comb
    begin
        top_ext  = CMP_W'(slowest) << LOAD_FRAC_BITS;
        prod_ext = CMP_W'(prod_reg);
        diff     = top_ext - prod_ext;
        // truncate toward zero, clamp at the fastest state
        if (prod_ext >= top_ext)
            od_val = '0;
        else
            od_val = COUNT_W'(diff >> LOAD_FRAC_BITS);

        // a lowered count pulls the current state back to the slowest one first
        if (COUNT_W'(current_state_reg) > slowest)
            cur_sat = slowest;
        else
            cur_sat = COUNT_W'(current_state_reg);

        unique case (mode_reg)
            cpufg_pkg::GOV_POWERSAVE:
                next_val = slowest;
            cpufg_pkg::GOV_ONDEMAND:
                next_val = above_reg ? '0 : od_val;
            cpufg_pkg::GOV_CONSERVATIVE:
            begin
                priority if (above_reg)
                    next_val = (cur_sat != '0) ? cur_sat - COUNT_W'(1) : '0;
                else if (below_reg)
                    next_val = (cur_sat < slowest) ? cur_sat + COUNT_W'(1) : slowest;
                else
                    next_val = cur_sat;
            end
            default:
                next_val = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register and performance state.
    // ------------------------------------------------------------------
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [cpufg_pkg::PSTATE_W-1:0]  next_state_reg;
    logic                            state_changed_reg;
    logic                            above_up_reg;

    always_comb
    begin
        if (result_wr)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            current_state_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (result_wr)
                current_state_reg <= next_val[cpufg_pkg::PSTATE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_wr)
        begin
            next_state_reg    <= next_val[cpufg_pkg::PSTATE_W-1:0];
            state_changed_reg <= next_val != COUNT_W'(current_state_reg);
            above_up_reg      <= above_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_state    = next_state_reg;
    assign state_changed = state_changed_reg;
    assign above_up      = above_up_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CPUFG_ASSERT_NEXT(a_take_starts_mul, in_take, fsm_reg == cpufg_pkg::S_MUL_LOAD)
    `CPUFG_ASSERT_NEXT(a_state_tracks_out, result_wr,
        out_valid && (current_state_reg == next_state))
    `CPUFG_ASSERT_NEXT(a_above_matches, result_wr,
        above_up == (load_reg > cpufg_pkg::LOAD_W'(up_thr_reg)))
    `CPUFG_ASSERT_NEXT(a_ondemand_fast,
        result_wr && (mode_reg == cpufg_pkg::GOV_ONDEMAND) && above_reg, next_state == '0)

endmodule

// File: sim/tb.sv
// Self-checking testbench for the CPU frequency governor: directed and random load samples.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run sizing. The cycle limit covers the slowest legal run several times over:
    // ~560 samples, the long hold and all register traffic.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 150;
    localparam int RANDOM_ITEMS = 450;
    localparam int TAIL_ITEMS   = 40;
    localparam int SETTLE       = 6;

    // One decision of the governor, as the result port presents it.
    typedef struct packed {
        logic [cpufg_pkg::PSTATE_W-1:0] pstate;
        logic                           changed;
        logic                           above;
    } gov_result_t;

    logic                            clk;
    logic                            rst_n         = 1'b0;
    logic                            cfg_valid     = 1'b0;
    logic                            cfg_ready;
    logic [cpufg_pkg::IDX_W-1:0]     cfg_index     = '0;
    logic [cpufg_pkg::DATA_W-1:0]    cfg_data      = '0;
    logic                            in_valid      = 1'b0;
    logic                            in_stall;
    logic [cpufg_pkg::AVG_W-1:0]     avg_load      = '0;
    logic                            out_valid;
    logic                            out_stall     = 1'b0;
    logic [cpufg_pkg::PSTATE_W-1:0]  next_state;
    logic                            state_changed;
    logic                            above_up;

    // Shadow copy of the governor registers and of its performance state.
    cpufg_pkg::gov_mode_t            gov_mode      = cpufg_pkg::GOV_PERFORMANCE;
    logic [cpufg_pkg::COUNT_W-1:0]   gov_states    = cpufg_pkg::RST_STATE_COUNT;
    logic [cpufg_pkg::CORE_W-1:0]    gov_cores     = cpufg_pkg::RST_CORE_COUNT;
    logic [cpufg_pkg::THR_W-1:0]     gov_up        = cpufg_pkg::RST_UP_THRESHOLD;
    logic [cpufg_pkg::THR_W-1:0]     gov_down      = cpufg_pkg::RST_DOWN_THRESHOLD;
    logic [cpufg_pkg::PSTATE_W-1:0]  cur_pstate    = '0;

    // Samples waiting to be offered, and decisions waiting to come out.
    logic [cpufg_pkg::AVG_W-1:0]     load_samples_q[$];
    gov_result_t                     pending_decisions[$];

    int                   samples_queued   = 0;
    int                   samples_accepted = 0;
    int                   results_checked  = 0;
    int                   reg_writes       = 0;
    int                   settings_run     = 0;
    int                   state_changes    = 0;
    int                   above_hits       = 0;
    int                   mode_hits[4]     = '{0, 0, 0, 0};
    int                   err_count        = 0;
    int                   cycle_count      = 0;

    // Idle controls; the gap rates, tail flag and hold request are set per phase by the stimulus process.
    int                   send_gap_pct  = 0;
    int                   recv_gap_pct  = 0;
    bit                   quiet_tail    = 1'b0;
    bit                   hold_req      = 1'b0;
    int                   hold_cnt      = 0;
    int                   send_idle     = 0;
    int                   stall_left    = 0;

    cpu_frequency_governor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .avg_load      (avg_load),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .next_state    (next_state),
        .state_changed (state_changed),
        .above_up      (above_up)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Compute the decision for one sample and advance the shadow state.
    function automatic gov_result_t predict_governor(
        input logic [cpufg_pkg::AVG_W-1:0] sample);
        gov_result_t                    res;
        logic [63:0]                    scaled;
        logic [63:0]                    prod;
        logic [63:0]                    top;
        int unsigned                    eff_cnt;
        logic [cpufg_pkg::PSTATE_W-1:0] slowest;
        logic [cpufg_pkg::PSTATE_W-1:0] cur;
        logic [cpufg_pkg::PSTATE_W-1:0] pick;
        logic                           over;
        logic                           under;

        scaled = 64'(sample) * 64'(gov_cores);
        // A zero count means one state; anything past the limit saturates.
        if (gov_states == 0)
            eff_cnt = 1;
        else if (gov_states > cpufg_pkg::DEF_MAX_STATES)
            eff_cnt = cpufg_pkg::DEF_MAX_STATES;
        else
            eff_cnt = gov_states;
        slowest = cpufg_pkg::PSTATE_W'(eff_cnt - 1);
        over    = scaled > 64'(gov_up);
        under   = scaled < 64'(gov_down);

        case (gov_mode)
            cpufg_pkg::GOV_POWERSAVE:
                pick = slowest;
            cpufg_pkg::GOV_ONDEMAND:
            begin
                if (over)
                    pick = '0;
                else
                begin
                    prod = scaled * 64'(eff_cnt);
                    top  = 64'(slowest) << cpufg_pkg::DEF_LOAD_FRAC_BITS;
                    pick = (prod >= top) ? '0
                         : cpufg_pkg::PSTATE_W'((top - prod) >> cpufg_pkg::DEF_LOAD_FRAC_BITS);
                end
            end
            cpufg_pkg::GOV_CONSERVATIVE:
            begin
                // Pull a stale state back inside the range before stepping.
                cur = (cur_pstate > slowest) ? slowest : cur_pstate;
                if (over)
                    pick = (cur > 0) ? cur - 1'b1 : '0;
                else if (under)
                    pick = (cur < slowest) ? cur + 1'b1 : slowest;
                else
                    pick = cur;
            end
            default:
                pick = '0;
        endcase

        res.pstate  = pick;
        res.changed = (pick != cur_pstate);
        res.above   = over;
        cur_pstate  = pick;
        mode_hits[int'(gov_mode)]++;
        if (res.changed)
            state_changes++;
        if (over)
            above_hits++;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want_v);
        err_count++;
    endtask

    // Write one register and mirror it into the shadow copy once the write lands.
    task automatic write_reg(input logic [cpufg_pkg::IDX_W-1:0] idx,
                             input logic [cpufg_pkg::DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            cpufg_pkg::CFG_GOVERNOR_MODE:
                gov_mode = cpufg_pkg::gov_mode_t'(val[cpufg_pkg::MODE_W-1:0]);
            cpufg_pkg::CFG_STATE_COUNT:    gov_states = val[cpufg_pkg::COUNT_W-1:0];
            cpufg_pkg::CFG_CORE_COUNT:     gov_cores  = val[cpufg_pkg::CORE_W-1:0];
            cpufg_pkg::CFG_UP_THRESHOLD:   gov_up     = val[cpufg_pkg::THR_W-1:0];
            cpufg_pkg::CFG_DOWN_THRESHOLD: gov_down   = val[cpufg_pkg::THR_W-1:0];
            default:                       ;
        endcase
        reg_writes++;
    endtask

    task automatic push_load(input logic [cpufg_pkg::AVG_W-1:0] sample);
        load_samples_q.push_back(sample);
        samples_queued++;
    endtask

    // Block until every queued sample went in and its decision came out,
    // then let the pipeline settle.
    task automatic wait_drained();
        while (samples_accepted != samples_queued || pending_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic int gap_choice();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // Draw a fresh register setting and write all five registers in a rotated order.
    task automatic pick_setting();
        logic [cpufg_pkg::DATA_W-1:0] vals[5];
        int                           span;
        int                           start;
        int                           k;

        vals[cpufg_pkg::CFG_GOVERNOR_MODE] = cpufg_pkg::DATA_W'($urandom);
        if ($urandom_range(9) == 0)
            vals[cpufg_pkg::CFG_STATE_COUNT] = cpufg_pkg::DATA_W'($urandom);
        else
            vals[cpufg_pkg::CFG_STATE_COUNT] =
                cpufg_pkg::DATA_W'($urandom_range(1, cpufg_pkg::DEF_MAX_STATES));
        case ($urandom_range(9))
            0:       vals[cpufg_pkg::CFG_CORE_COUNT] = cpufg_pkg::DATA_W'($urandom);
            1, 2:    vals[cpufg_pkg::CFG_CORE_COUNT] = cpufg_pkg::DATA_W'(64);
            default: vals[cpufg_pkg::CFG_CORE_COUNT] =
                         cpufg_pkg::DATA_W'($urandom_range(1, 64));
        endcase
        // Keep most thresholds inside the reachable scaled-load range.
        span = ((vals[cpufg_pkg::CFG_CORE_COUNT][cpufg_pkg::CORE_W-1:0] == 0) ? 1
                : int'(vals[cpufg_pkg::CFG_CORE_COUNT][cpufg_pkg::CORE_W-1:0]))
               << cpufg_pkg::DEF_LOAD_FRAC_BITS;
        if ($urandom_range(7) == 0)
        begin
            vals[cpufg_pkg::CFG_UP_THRESHOLD]   = cpufg_pkg::DATA_W'($urandom);
            vals[cpufg_pkg::CFG_DOWN_THRESHOLD] = cpufg_pkg::DATA_W'($urandom);
        end
        else
        begin
            vals[cpufg_pkg::CFG_UP_THRESHOLD] = cpufg_pkg::DATA_W'($urandom_range(span));
            vals[cpufg_pkg::CFG_DOWN_THRESHOLD] =
                cpufg_pkg::DATA_W'($urandom_range(int'(vals[cpufg_pkg::CFG_UP_THRESHOLD])));
        end

        start = $urandom_range(4);
        for (k = 0; k < 5; k++)
            write_reg(cpufg_pkg::IDX_W'((start + k) % 5), vals[(start + k) % 5]);
        // Now and then poke an unmapped index; it must change nothing.
        if ($urandom_range(5) == 0)
            write_reg(cpufg_pkg::IDX_W'($urandom_range(int'(cpufg_pkg::CFG_DOWN_THRESHOLD) + 1,
                                                       (1 << cpufg_pkg::IDX_W) - 1)),
                      cpufg_pkg::DATA_W'($urandom));
        settings_run++;
    endtask

    function automatic logic [cpufg_pkg::AVG_W-1:0] random_load();
        case ($urandom_range(9))
            0:       return cpufg_pkg::AVG_W'($urandom);
            1:       return (gov_cores == 0) ? cpufg_pkg::AVG_W'($urandom_range(65536))
                            : cpufg_pkg::AVG_W'(gov_up / gov_cores + $urandom_range(1));
            2:       return (gov_cores == 0) ? cpufg_pkg::AVG_W'(0)
                            : cpufg_pkg::AVG_W'(gov_down / gov_cores + $urandom_range(1));
            3:       return $urandom_range(1) ? cpufg_pkg::AVG_W'(65536) : cpufg_pkg::AVG_W'(0);
            default: return cpufg_pkg::AVG_W'($urandom_range(65536));
        endcase
    endfunction

    // Sample driver: offer the next queued sample whenever the channel is free,
    // with random idle bursts between transactions.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            avg_load <= '0;
            send_idle = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pending_decisions.push_back(predict_governor(avg_load));
                samples_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_idle != 0)
                begin
                    send_idle--;
                    in_valid <= 1'b0;
                end
                else if (load_samples_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    avg_load <= load_samples_q.pop_front();
                    if (!quiet_tail && $urandom_range(99) < send_gap_pct)
                        send_idle = $urandom_range(1, 10);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so it runs regardless of the burst stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_req)
            hold_cnt <= LONG_HOLD;
    end

    // Result monitor: check each transaction against the oldest pending decision,
    // and drive random stall bursts on the result side.
    always @(posedge clk or negedge rst_n)
    begin
        gov_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_decisions.size() == 0)
                    report_mismatch("result with nothing pending, next_state", next_state, -1);
                else
                begin
                    want = pending_decisions.pop_front();
                    if (next_state !== want.pstate)
                        report_mismatch("next_state", next_state, want.pstate);
                    if (state_changed !== want.changed)
                        report_mismatch("state_changed", state_changed, want.changed);
                    if (above_up !== want.above)
                        report_mismatch("above_up", above_up, want.above);
                    results_checked++;
                end
            end
            if (stall_left != 0)
                stall_left--;
            else if (!quiet_tail && $urandom_range(99) < recv_gap_pct)
                stall_left = $urandom_range(1, 10);
            out_stall <= (stall_left != 0) || (hold_cnt != 0);
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d decisions still pending",
                     cycle_count, pending_decisions.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int n;
        int random_sent;
        int k;

        phase       = 0;
        random_sent = 0;

        // Hold reset, then release it on a clock edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset values: performance, one state, one core; include an out-of-range load.
        push_load(cpufg_pkg::AVG_W'(0));
        push_load(cpufg_pkg::AVG_W'(65536));
        push_load(cpufg_pkg::AVG_W'((1 << cpufg_pkg::AVG_W) - 1));
        wait_drained();

        // Ondemand over the full sixteen states, default thresholds.
        // Hit the exact threshold, one above it, and the linear region.
        write_reg(cpufg_pkg::CFG_GOVERNOR_MODE, cpufg_pkg::DATA_W'(cpufg_pkg::GOV_ONDEMAND));
        write_reg(cpufg_pkg::CFG_STATE_COUNT, cpufg_pkg::DATA_W'(16));
        push_load(cpufg_pkg::AVG_W'(0));
        push_load(cpufg_pkg::AVG_W'(65536));
        push_load(cpufg_pkg::AVG_W'(52429));
        push_load(cpufg_pkg::AVG_W'(52430));
        push_load(cpufg_pkg::AVG_W'(32768));
        wait_drained();

        // Conservative, 64 cores, up threshold 4194304: step, keep on equality, step back.
        write_reg(cpufg_pkg::CFG_GOVERNOR_MODE,
                  cpufg_pkg::DATA_W'(cpufg_pkg::GOV_CONSERVATIVE));
        write_reg(cpufg_pkg::CFG_CORE_COUNT, cpufg_pkg::DATA_W'(64));
        write_reg(cpufg_pkg::CFG_UP_THRESHOLD, cpufg_pkg::DATA_W'(4194304));
        write_reg(cpufg_pkg::CFG_DOWN_THRESHOLD, cpufg_pkg::DATA_W'(65536));
        push_load(cpufg_pkg::AVG_W'(0));
        push_load(cpufg_pkg::AVG_W'(65537));
        push_load(cpufg_pkg::AVG_W'(65536));
        push_load(cpufg_pkg::AVG_W'(1024));
        push_load(cpufg_pkg::AVG_W'(1023));
        wait_drained();

        // Powersave with an oversized state count: saturates to the slowest state.
        write_reg(cpufg_pkg::CFG_GOVERNOR_MODE, cpufg_pkg::DATA_W'(cpufg_pkg::GOV_POWERSAVE));
        write_reg(cpufg_pkg::CFG_STATE_COUNT, cpufg_pkg::DATA_W'(31));
        push_load(cpufg_pkg::AVG_W'(100));
        push_load(cpufg_pkg::AVG_W'((1 << cpufg_pkg::AVG_W) - 1));
        wait_drained();

        // Conservative saturating at the slow end.
        write_reg(cpufg_pkg::CFG_GOVERNOR_MODE,
                  cpufg_pkg::DATA_W'(cpufg_pkg::GOV_CONSERVATIVE));
        push_load(cpufg_pkg::AVG_W'(0));
        wait_drained();

        // Shrink the state count under a high state; it must be clamped first.
        write_reg(cpufg_pkg::CFG_STATE_COUNT, cpufg_pkg::DATA_W'(4));
        push_load(cpufg_pkg::AVG_W'(2000));
        wait_drained();

        // Both tests true: up must win; a zero load steps slower. Then walk to the fast end and saturate there.
        write_reg(cpufg_pkg::CFG_UP_THRESHOLD, cpufg_pkg::DATA_W'(0));
        write_reg(cpufg_pkg::CFG_DOWN_THRESHOLD,
                  cpufg_pkg::DATA_W'((1 << cpufg_pkg::THR_W) - 1));
        write_reg(cpufg_pkg::CFG_CORE_COUNT, cpufg_pkg::DATA_W'(1));
        push_load(cpufg_pkg::AVG_W'(5));
        push_load(cpufg_pkg::AVG_W'(0));
        for (k = 0; k < 4; k++)
            push_load(cpufg_pkg::AVG_W'(65536));
        wait_drained();

        // Ondemand with zero state count and zero cores.
        write_reg(cpufg_pkg::CFG_GOVERNOR_MODE, cpufg_pkg::DATA_W'(cpufg_pkg::GOV_ONDEMAND));
        write_reg(cpufg_pkg::CFG_STATE_COUNT, cpufg_pkg::DATA_W'(0));
        write_reg(cpufg_pkg::CFG_CORE_COUNT, cpufg_pkg::DATA_W'(0));
        push_load(cpufg_pkg::AVG_W'(77));
        push_load(cpufg_pkg::AVG_W'((1 << cpufg_pkg::AVG_W) - 1));
        wait_drained();

        // Unmapped index must be ignored; back to performance.
        write_reg(cpufg_pkg::IDX_W'(int'(cpufg_pkg::CFG_DOWN_THRESHOLD) + 1),
                  cpufg_pkg::DATA_W'((1 << cpufg_pkg::DATA_W) - 1));
        write_reg(cpufg_pkg::IDX_W'((1 << cpufg_pkg::IDX_W) - 1), cpufg_pkg::DATA_W'(0));
        write_reg(cpufg_pkg::CFG_GOVERNOR_MODE,
                  cpufg_pkg::DATA_W'(cpufg_pkg::GOV_PERFORMANCE));
        push_load(cpufg_pkg::AVG_W'(65536));
        wait_drained();

        // Random phases: new setting, random idle mix or, in phase 2, a long receiver hold, a batch of samples.
        while (random_sent < RANDOM_ITEMS)
        begin
            pick_setting();
            if (phase == 2)
            begin
                // Keep offering samples while the receiver holds off for a long stretch,
                // so the block backs up and stalls its input.
                send_gap_pct = 0;
                recv_gap_pct = 0;
                n = 40;
                for (k = 0; k < n; k++)
                    push_load(random_load());
                hold_req = 1'b1;
                while (hold_cnt == 0)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                send_gap_pct = gap_choice();
                recv_gap_pct = gap_choice();
                n = $urandom_range(10, 50);
                for (k = 0; k < n; k++)
                    push_load(random_load());
            end
            random_sent += n;
            phase++;
            wait_drained();
        end

        // Tail: full speed on both sides.
        quiet_tail = 1'b1;
        pick_setting();
        for (k = 0; k < TAIL_ITEMS; k++)
            push_load(random_load());
        wait_drained();

        if (pending_decisions.size() != 0)
            report_mismatch("decisions never delivered", 0, pending_decisions.size());

        $display("covered %0d load samples over %0d settings with %0d register writes",
                 samples_accepted, settings_run, reg_writes);
        $display("decisions: performance %0d, powersave %0d, ondemand %0d, conservative %0d; "
                 , mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
                 "%0d state changes, %0d above threshold, %0d results checked",
                 state_changes, above_hits, results_checked);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: cpu_frequency_governor.f
+incdir+sv
sv/cpufg_pkg.sv
sv/cpu_frequency_governor.sv
sim/tb.sv
